@@ rtl/core/mts_pkg.sv @@
`default_nettype none
package mts_pkg;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PAUSED  = 2'd1,
        MODE_PLAYING = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUTTON = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] REG_BEAT     = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FETCH,
        S_PDIV,
        S_DUTY,
        S_LEN,
        S_OUT
    } t_state;

    localparam logic [36:0] PERIOD_NUM   = 37'd100000000000;
    localparam logic [17:0] LEN_NUM      = 18'd240000;
    localparam logic [9:0]  DEBOUNCE_SAT = 10'd1023;
    localparam logic [8:0]  BEAT_RESET   = 9'd120;
    localparam logic [9:0]  DEB_RESET    = 10'd20;

    typedef struct packed {
        logic [1:0]  op;
        logic [20:0] note_frequency;
        logic [7:0]  note_length;
        logic        load_first;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  player_state;
        logic        pwm_enable;
        logic [36:0] pwm_period_ns;
        logic [36:0] pwm_duty_ns;
        logic [7:0]  note_position;
        logic [7:0]  notes_loaded;
    } t_out_word;

endpackage
`default_nettype wire

@@ rtl/core/melody_tone_sequencer.sv @@
// Flow: a load, pause or idle tick answers from the fetch state, after the table read; a note start reads the table
// and runs restoring dividers one quotient bit per cycle for the period, the duty and each
// of seven length figures; a rest skips the period and duty divisions.
// Throughput: one word at a time; the next word is taken once the result is accepted.
// Reset: synchronous active low; player stopped, table empty, beat 120, debounce 20.
`default_nettype none
module melody_tone_sequencer #(
    parameter int MAX_NOTES = 128
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  mts_pkg::t_in_word i_data,
    output logic              o_valid,
    input  wire               i_stall,
    output mts_pkg::t_out_word o_data,
    input  wire               i_cfg_we,
    input  wire [0:0]         i_cfg_index,
    input  wire [9:0]         i_cfg_data
);

    localparam int AW = $clog2(MAX_NOTES);
    localparam int CW = $clog2(MAX_NOTES + 1);

    // note table
    logic [28:0] r_mem [MAX_NOTES];
    logic [28:0] r_rd;

    mts_pkg::t_state r_state, n_state;
    mts_pkg::t_mode  r_mode;
    logic        r_start;
    logic [8:0]  r_beat;
    logic [9:0]  r_deb_ms, r_deb_cnt;
    logic [CW-1:0] r_pos, r_cnt;
    logic [18:0] r_rem;
    logic [36:0] r_per, r_duty;
    logic        r_on;
    logic [1:0]  r_status;
    logic        r_out_v;
    mts_pkg::t_out_word r_out;

    // shared divider: remainder, quotient, divisor
    logic [39:0] r_rmd;
    logic [39:0] r_quo;
    logic [39:0] r_dvs;
    logic [5:0]  r_bit;
    logic [2:0]  r_li;
    logic [20:0] r_freq;
    logic [7:0]  r_len;

    logic [40:0] w_sh;
    logic        w_ge;
    logic [39:0] w_nrem;
    logic [36:0] w_qn;
    logic        w_busy;
    logic        w_take;
    logic        w_go;
    logic [16:0] w_d;
    logic [25:0] w_bd;

    assign w_busy  = (r_state != mts_pkg::S_IDLE) || r_out_v;
    assign o_stall = w_busy;
    assign w_take  = i_valid && !w_busy;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // a note starts when a start was requested, r_pos is below the loaded count and the entry is not all zero
    assign w_go = r_start && (r_pos < r_cnt) && (r_rd != 29'd0);

    assign w_sh   = {r_rmd, r_quo[39]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_nrem = w_ge ? 40'(w_sh - {1'b0, r_dvs}) : w_sh[39:0];
    assign w_qn   = {r_quo[35:0], w_ge};

    // divisor for note figure r_li: beat * 2^i, times 3/2 for triplets
    always_comb begin
        w_d = 17'(7'd1 << r_li);
        if (r_len[7]) w_d = 17'((w_d * 17'd3) >> 1);
        w_bd = 26'((r_beat == 9'd0 ? 9'd1 : r_beat)) * 26'(w_d);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mts_pkg::S_IDLE: if (w_take) n_state = mts_pkg::S_READ;
            mts_pkg::S_READ: n_state = mts_pkg::S_FETCH;
            mts_pkg::S_FETCH: n_state = w_go ? mts_pkg::S_PDIV : mts_pkg::S_IDLE;
            mts_pkg::S_PDIV: if (r_bit == 6'd0) n_state = mts_pkg::S_DUTY;
            mts_pkg::S_DUTY: if (r_bit == 6'd0) n_state = mts_pkg::S_LEN;
            mts_pkg::S_LEN:
                if (r_bit == 6'd0 && r_li == 3'd6) n_state = mts_pkg::S_OUT;
            mts_pkg::S_OUT: n_state = mts_pkg::S_IDLE;
            default: n_state = mts_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mts_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // table port
    always_ff @(posedge i_clk) begin
        if (w_take && i_data.op == mts_pkg::OP_LOAD && r_mode != mts_pkg::MODE_PLAYING
            && (i_data.load_first || r_cnt < CW'(MAX_NOTES))) begin
            r_mem[i_data.load_first ? AW'(0) : r_cnt[AW-1:0]] <=
                {i_data.note_frequency, i_data.note_length};
        end
        r_rd <= r_mem[r_pos[AW-1:0]];
    end

    // datapath and player state
    always_ff @(posedge i_clk) begin
        logic       start;
        logic [1:0] status;
        start = 1'b0;
        status = mts_pkg::ST_OK;
        if (!i_rst_n) begin
            r_mode <= mts_pkg::MODE_STOPPED;
            r_beat <= mts_pkg::BEAT_RESET;
            r_deb_ms <= mts_pkg::DEB_RESET;
            r_deb_cnt <= mts_pkg::DEBOUNCE_SAT;
            r_pos <= '0;
            r_cnt <= '0;
            r_rem <= '0;
            r_per <= '0;
            r_duty <= '0;
            r_on <= 1'b0;
            r_out_v <= 1'b0;
            r_status <= mts_pkg::ST_OK;
        end else begin
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == mts_pkg::REG_BEAT[0]) r_beat <= i_cfg_data[8:0];
                else r_deb_ms <= i_cfg_data;
            end
            unique case (r_state)
                mts_pkg::S_IDLE: if (w_take) begin
                    unique case (i_data.op)
                        mts_pkg::OP_LOAD: begin
                            if (r_mode == mts_pkg::MODE_PLAYING) status = mts_pkg::ST_BUSY;
                            else begin
                                r_mode <= mts_pkg::MODE_STOPPED;
                                r_on <= 1'b0;
                                if (i_data.load_first) r_cnt <= CW'(1);
                                else if (r_cnt < CW'(MAX_NOTES)) r_cnt <= CW'(r_cnt + 1'b1);
                                else status = mts_pkg::ST_FULL;
                            end
                        end
                        mts_pkg::OP_BUTTON: if (r_deb_cnt >= r_deb_ms) begin
                            r_deb_cnt <= '0;
                            if (r_mode == mts_pkg::MODE_PLAYING) begin
                                r_mode <= mts_pkg::MODE_PAUSED;
                                r_on <= 1'b0;
                                r_rem <= '0;
                            end else begin
                                if (r_mode == mts_pkg::MODE_STOPPED) r_pos <= '0;
                                r_mode <= mts_pkg::MODE_PLAYING;
                                start = 1'b1;
                            end
                        end
                        mts_pkg::OP_TICK: begin
                            if (r_deb_cnt != mts_pkg::DEBOUNCE_SAT)
                                r_deb_cnt <= r_deb_cnt + 10'd1;
                            if (r_mode == mts_pkg::MODE_PLAYING) begin
                                if (r_rem > 19'd1) r_rem <= r_rem - 19'd1;
                                else begin
                                    r_rem <= '0;
                                    start = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    r_status <= status;
                    r_start <= start;
                end
                mts_pkg::S_FETCH: begin
                    // r_rd holds entry at r_pos
                    if (w_go) begin
                        r_freq <= r_rd[28:8];
                        r_len <= r_rd[7:0];
                        r_pos <= CW'(r_pos + 1'b1);
                        r_rmd <= '0;
                        r_quo <= 40'(mts_pkg::PERIOD_NUM) + 40'(r_rd[28:9]);
                        r_dvs <= 40'(r_rd[28:8]);
                        r_bit <= (r_rd[28:8] != 21'd0) ? 6'd39 : 6'd0;
                        r_li <= 3'd0;
                    end else begin
                        // no note starts: stop on a start request, answer at once
                        if (r_start) begin
                            r_mode <= mts_pkg::MODE_STOPPED;
                            r_on <= 1'b0;
                        end
                        r_out_v <= 1'b1;
                        r_out.status <= r_status;
                        r_out.player_state <= r_start ? mts_pkg::MODE_STOPPED : r_mode;
                        r_out.pwm_enable <= r_start ? 1'b0 : r_on;
                        r_out.pwm_period_ns <= r_per;
                        r_out.pwm_duty_ns <= r_duty;
                        r_out.note_position <= 8'(r_pos);
                        r_out.notes_loaded <= 8'(r_cnt);
                    end
                end
                mts_pkg::S_PDIV: begin
                    if (r_bit != 6'd0) begin
                        r_rmd <= w_nrem;
                        r_quo <= {r_quo[38:0], w_ge};
                        r_bit <= r_bit - 6'd1;
                    end else begin
                        if (r_freq != 21'd0) begin
                            r_per <= w_qn;
                            r_on <= 1'b1;
                            // duty: (period*7 + 5) / 10, same as rounding 70 percent
                            r_rmd <= '0;
                            r_quo <= {w_qn, 3'b000} - 40'(w_qn) + 40'd5;
                            r_dvs <= 40'd10;
                            r_bit <= 6'd39;
                        end else begin
                            r_per <= '0;
                            r_duty <= '0;
                            r_on <= 1'b0;
                        end
                        r_rem <= '0;
                    end
                end
                mts_pkg::S_DUTY: begin
                    if (r_bit != 6'd0) begin
                        r_rmd <= w_nrem;
                        r_quo <= {r_quo[38:0], w_ge};
                        r_bit <= r_bit - 6'd1;
                    end else begin
                        if (r_freq != 21'd0) r_duty <= w_qn;
                        r_li <= 3'd0;
                        r_rmd <= '0;
                        r_quo <= 40'(mts_pkg::LEN_NUM) << 22;
                        r_dvs <= 40'(w_bd);
                        r_bit <= 6'd17;
                    end
                end
                mts_pkg::S_LEN: begin
                    if (r_bit != 6'd0) begin
                        r_rmd <= w_nrem;
                        r_quo <= {r_quo[38:0], w_ge};
                        r_bit <= r_bit - 6'd1;
                    end else begin
                        if (r_len[r_li])
                            r_rem <= r_rem + 19'({r_quo[16:0], w_ge});
                        // advance to the next figure and its divisor
                        if (r_li != 3'd6) begin
                            r_li <= r_li + 3'd1;
                            r_rmd <= '0;
                            r_quo <= 40'(mts_pkg::LEN_NUM) << 22;
                            r_bit <= 6'd17;
                            r_dvs <= 40'(26'((r_beat == 9'd0 ? 9'd1 : r_beat))
                                * 26'(r_len[7] ? 17'(((17'd1 << (r_li + 3'd1)) * 17'd3) >> 1)
                                               : 17'(17'd1 << (r_li + 3'd1))));
                        end
                    end
                end
                mts_pkg::S_OUT: begin
                    r_out_v <= 1'b1;
                    r_out.status <= r_status;
                    r_out.player_state <= r_mode;
                    r_out.pwm_enable <= r_on;
                    r_out.pwm_period_ns <= r_per;
                    r_out.pwm_duty_ns <= r_duty;
                    r_out.note_position <= 8'(r_pos);
                    r_out.notes_loaded <= 8'(r_cnt);
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> o_stall) else $error("word taken while result pending");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_NOTES)) else $error("note count overflow");
    a_tone_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on && r_state == mts_pkg::S_IDLE) |-> r_mode == mts_pkg::MODE_PLAYING)
        else $error("tone on while not playing");
`endif

endmodule
`default_nettype wire
